// ===== sv/blr_pkg.sv =====
// Shared types and constants for the Bresenham line rasterizer.
// No dependencies; used by the channel interfaces and the top level.
package blr_pkg;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } cmd_t;

endpackage

// ===== sv/blr_if.sv =====
// Valid/ready channel interfaces for the line rasterizer: command in, pixel out.
// Depends on blr_pkg for the command type.
interface blr_cmd_if #(
  parameter int COORD_BITS = 12
);
  logic                         valid;
  logic                         ready;
  blr_pkg::cmd_t                cmd;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;

  modport source(output valid, cmd, start_x, start_y, end_x, end_y, input ready);
  modport sink(input valid, cmd, start_x, start_y, end_x, end_y, output ready);
endinterface

interface blr_pixel_if #(
  parameter int COORD_BITS = 12
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic                         last_pixel;

  modport source(output valid, pixel_x, pixel_y, last_pixel, input ready);
  modport sink(input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

// ===== sv/bresenham_line_rasterizer.sv =====
// A command is held in the input register, and its pixel, if any, then in the result register.
// One command per cycle while the pixel output is not stalled; each step is a single
// pass through the error-term adder and the position incrementers into the result register.
// Reset (rst, synchronous, active high) clears the line state, the input and result valids.
// Depends on blr_pkg and the channel interfaces in blr_if.sv.
module bresenham_line_rasterizer #(
  parameter int COORD_BITS = 12
) (
  input  logic               clk,
  input  logic               rst,
  blr_cmd_if.sink            line_cmd,
  blr_pixel_if.source        pixel
);

  localparam int CW = COORD_BITS;
  localparam int EW = COORD_BITS + 2;

  // input register
  logic          s1_valid;
  blr_pkg::cmd_t s1_cmd;
  logic [CW-1:0] s1_sx, s1_sy, s1_ex, s1_ey;

  // line state
  logic [CW-1:0] pos_x, pos_y;
  logic [CW-1:0] major_remaining;
  logic [EW-1:0] error_term;
  logic [CW-1:0] delta_x_abs, delta_y_abs;
  logic          x_step_negative, y_step_negative, steep_line, line_active;

  // result register
  logic          o_valid;
  logic [CW-1:0] o_x, o_y;
  logic          o_last;

  logic s1_fire, in_fire;

  // next values
  logic [CW-1:0] pos_x_next, pos_y_next, major_remaining_next;
  logic [EW-1:0] error_term_next;
  logic [CW-1:0] delta_x_abs_next, delta_y_abs_next;
  logic          x_step_negative_next, y_step_negative_next, steep_line_next;
  logic          line_active_next, has_result, last_next;

  // load datapath
  logic [CW:0]   dx, dy, dx_neg, dy_neg;
  logic [CW-1:0] ld_dx_abs, ld_dy_abs, ld_major, ld_minor;
  logic          ld_steep;

  // step datapath
  logic [CW-1:0] st_major, st_minor, x_inc, y_inc, rem_dec;
  logic [EW-1:0] diff, err_add;
  logic          err_nonneg;

  assign s1_fire = s1_valid && (!o_valid || pixel.ready);
  assign line_cmd.ready = !s1_valid || s1_fire;
  assign in_fire = line_cmd.valid && line_cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (line_cmd.ready) begin
      s1_valid <= line_cmd.valid;
    end
    if (in_fire) begin
      s1_cmd <= line_cmd.cmd;
      s1_sx  <= line_cmd.start_x;
      s1_sy  <= line_cmd.start_y;
      s1_ex  <= line_cmd.end_x;
      s1_ey  <= line_cmd.end_y;
    end
  end

  always_comb begin
    dx        = {s1_ex[CW-1], s1_ex} - {s1_sx[CW-1], s1_sx};
    dy        = {s1_ey[CW-1], s1_ey} - {s1_sy[CW-1], s1_sy};
    dx_neg    = -dx;
    dy_neg    = -dy;
    ld_dx_abs = dx[CW] ? dx_neg[CW-1:0] : dx[CW-1:0];
    ld_dy_abs = dy[CW] ? dy_neg[CW-1:0] : dy[CW-1:0];
    ld_steep  = ld_dy_abs > ld_dx_abs;
    ld_major  = ld_steep ? ld_dy_abs : ld_dx_abs;
    ld_minor  = ld_steep ? ld_dx_abs : ld_dy_abs;

    st_major   = steep_line ? delta_y_abs : delta_x_abs;
    st_minor   = steep_line ? delta_x_abs : delta_y_abs;
    x_inc      = x_step_negative ? {CW{1'b1}} : CW'(1);
    y_inc      = y_step_negative ? {CW{1'b1}} : CW'(1);
    err_nonneg = !error_term[EW-1];
    diff       = {2'b00, st_minor} - {2'b00, st_major};
    err_add    = err_nonneg ? {diff[EW-2:0], 1'b0} : {1'b0, st_minor, 1'b0};
    rem_dec    = major_remaining - CW'(1);

    pos_x_next           = pos_x;
    pos_y_next           = pos_y;
    major_remaining_next = major_remaining;
    error_term_next      = error_term;
    delta_x_abs_next     = delta_x_abs;
    delta_y_abs_next     = delta_y_abs;
    x_step_negative_next = x_step_negative;
    y_step_negative_next = y_step_negative;
    steep_line_next      = steep_line;
    line_active_next     = line_active;
    has_result           = 1'b0;
    last_next            = 1'b0;

    unique case (s1_cmd)
      blr_pkg::CMD_LOAD: begin
        pos_x_next           = s1_sx;
        pos_y_next           = s1_sy;
        major_remaining_next = ld_major;
        error_term_next      = {1'b0, ld_minor, 1'b0} - {2'b00, ld_major};
        delta_x_abs_next     = ld_dx_abs;
        delta_y_abs_next     = ld_dy_abs;
        x_step_negative_next = dx[CW];
        y_step_negative_next = dy[CW];
        steep_line_next      = ld_steep;
        line_active_next     = ld_major != '0;
        has_result           = 1'b1;
        last_next            = ld_major == '0;
      end
      blr_pkg::CMD_STEP: begin
        if (line_active) begin
          // major axis always moves; minor axis moves when the error is not negative
          if (steep_line || err_nonneg) pos_y_next = pos_y + y_inc;
          if (!steep_line || err_nonneg) pos_x_next = pos_x + x_inc;
          error_term_next      = error_term + err_add;
          major_remaining_next = rem_dec;
          line_active_next     = rem_dec != '0;
          has_result           = 1'b1;
          last_next            = rem_dec == '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x           <= '0;
      pos_y           <= '0;
      major_remaining <= '0;
      error_term      <= '0;
      delta_x_abs     <= '0;
      delta_y_abs     <= '0;
      x_step_negative <= 1'b0;
      y_step_negative <= 1'b0;
      steep_line      <= 1'b0;
      line_active     <= 1'b0;
    end else if (s1_fire) begin
      pos_x           <= pos_x_next;
      pos_y           <= pos_y_next;
      major_remaining <= major_remaining_next;
      error_term      <= error_term_next;
      delta_x_abs     <= delta_x_abs_next;
      delta_y_abs     <= delta_y_abs_next;
      x_step_negative <= x_step_negative_next;
      y_step_negative <= y_step_negative_next;
      steep_line      <= steep_line_next;
      line_active     <= line_active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else begin
      o_valid <= (o_valid && !pixel.ready) || (s1_fire && has_result);
    end
    if (s1_fire && has_result) begin
      o_x    <= pos_x_next;
      o_y    <= pos_y_next;
      o_last <= last_next;
    end
  end

  assign pixel.valid      = o_valid;
  assign pixel.pixel_x    = o_x;
  assign pixel.pixel_y    = o_y;
  assign pixel.last_pixel = o_last;

endmodule

// ===== sv/blr_checker.sv =====
// Port-level checks for the line rasterizer, attached by bind.
// Depends on bresenham_line_rasterizer and its channel interfaces.
module blr_checker #(
  parameter int COORD_BITS = 12
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [COORD_BITS-1:0] out_x,
  input logic [COORD_BITS-1:0] out_y,
  input logic                  out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("pixel valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_x) && $stable(out_y) && $stable(out_last))
    else $error("pixel changed while stalled");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("pixel valid after reset");

  // a fresh pixel follows its command via input and result registers
  a_rise_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("pixel without a command two cycles earlier");

endmodule

bind bresenham_line_rasterizer blr_checker #(.COORD_BITS(COORD_BITS)) u_blr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (line_cmd.valid),
  .in_ready  (line_cmd.ready),
  .out_valid (pixel.valid),
  .out_ready (pixel.ready),
  .out_x     (pixel.pixel_x),
  .out_y     (pixel.pixel_y),
  .out_last  (pixel.last_pixel)
);
